[rtl/lbp_pkg.sv]
`default_nettype none

package lbp_pkg;

  // Scan limits
  localparam int TRACE_LIMIT    = 64;
  localparam int HOST_REG_LIMIT = 6;

  // Fixed field widths
  localparam int ADDR_W  = 64;
  localparam int WORD_W  = 32;
  localparam int CNT_W   = 7;
  localparam int MASK_W  = 32;
  localparam int POP_W   = 6;

  // Budget register reset value
  localparam logic [CNT_W-1:0] BUDGET_RESET = 7'd64;

  // Trace limit clipped to what the budget register can express
  localparam logic [CNT_W-1:0] TRACE_CAP =
    CNT_W'((TRACE_LIMIT < 127) ? TRACE_LIMIT : 127);

  // Major opcodes
  localparam logic [6:0] OPC_LOAD      = 7'h03;
  localparam logic [6:0] OPC_STORE     = 7'h23;
  localparam logic [6:0] OPC_OP_IMM    = 7'h13;
  localparam logic [6:0] OPC_OP_IMM_32 = 7'h1B;
  localparam logic [6:0] OPC_OP        = 7'h33;
  localparam logic [6:0] OPC_OP_32     = 7'h3B;
  localparam logic [6:0] OPC_AUIPC     = 7'h17;
  localparam logic [6:0] OPC_LUI       = 7'h37;
  localparam logic [6:0] OPC_BRANCH    = 7'h63;

  // funct7 of the M extension under OP and OP-32
  localparam logic [6:0] FUNCT7_MULDIV = 7'h01;

  // One result item
  typedef struct packed {
    logic              done_res;
    logic              found_loop;
    logic [CNT_W-1:0]  loop_length;
    logic [MASK_W-1:0] preload_mask;
    logic [POP_W-1:0]  preload_count;
  } lbp_res_t;

  // One-hot bit for a register number, x0 gives nothing
  function automatic logic [MASK_W-1:0] reg_bit(input logic [4:0] r);
    logic [MASK_W-1:0] m;
    m = '0;
    if (r != 5'd0) begin
      m[r] = 1'b1;
    end
    return m;
  endfunction

  // Population count of a register mask
  function automatic logic [POP_W-1:0] pop_mask(input logic [MASK_W-1:0] v);
    logic [POP_W-1:0] c;
    c = '0;
    for (int i = 0; i < MASK_W; i++) begin
      c = c + POP_W'(v[i]);
    end
    return c;
  endfunction

  // Sign-extended B-type immediate
  function automatic logic [ADDR_W-1:0] branch_offset(input logic [WORD_W-1:0] w);
    return {{(ADDR_W-13){w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  endfunction

endpackage

`default_nettype wire

[rtl/loop_backedge_prescan.sv]
`default_nettype none

// Loop backedge prescan: takes one fetched RV64 instruction word per request and answers
// each request with exactly one result, in order. A request with in_first high opens a
// scan whose head is its fetch address; the scan closes on a failed fetch, an unsupported
// opcode, an exhausted budget (min of cfg budget and the trace limit) or a conditional
// branch back to the head, and only the closing request carries done_res and the
// loop fields. It takes one request per clock while out_stall does not hold the result
// register. The request lands in the input register on the accepting edge, then one
// decode / 64-bit target add and compare / register-mask popcount pass carries it into
// the result register, which raises out_valid. Write the budget only while no request is in flight.
module loop_backedge_prescan
  import lbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,

  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,

  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_first,
  input  wire logic [ADDR_W-1:0] in_fetch_addr,
  input  wire logic [WORD_W-1:0] in_instr_word,
  input  wire logic              in_fetch_ok,

  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_done_res,
  output logic                   out_found_loop,
  output logic [CNT_W-1:0]       out_loop_length,
  output logic [MASK_W-1:0]      out_preload_mask,
  output logic [POP_W-1:0]       out_preload_count
);

  // Configuration
  logic [CNT_W-1:0]  budget_r;

  // Input register
  logic              s1_valid_r;
  logic              s1_first_r;
  logic [ADDR_W-1:0] s1_addr_r;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_ok_r;

  // Scan state
  logic [ADDR_W-1:0] head_r,   head_nxt;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [MASK_W-1:0] used_r,   used_nxt;
  logic              elig_r,   elig_nxt;
  logic              active_r, active_nxt;

  // Result register
  logic              out_valid_r;
  lbp_res_t          res_r, res_nxt;

  logic              out_hold;
  logic              advance;

  // Pipeline control
  assign out_hold = out_valid_r && out_stall;
  assign advance  = s1_valid_r && !out_hold;
  assign in_stall = s1_valid_r && out_hold;

  // Decode and scan step
  logic [6:0]        op;
  logic [4:0]        rd, rs1, rs2;
  logic [6:0]        funct7;
  logic [CNT_W-1:0]  limit;
  logic [ADDR_W-1:0] eff_head;
  logic [CNT_W-1:0]  eff_cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [MASK_W-1:0] eff_used;
  logic              eff_elig;
  logic              eff_active;
  logic              op_known;
  logic              is_branch;
  logic              backedge;
  logic              stop_early;
  logic              elig_mid;
  logic              collect_ok;
  logic [MASK_W-1:0] collect_bits;
  logic [MASK_W-1:0] used_upd;
  logic              elig_upd;
  logic [POP_W-1:0]  used_pop;

  assign op     = s1_word_r[6:0];
  assign rd     = s1_word_r[11:7];
  assign rs1    = s1_word_r[19:15];
  assign rs2    = s1_word_r[24:20];
  assign funct7 = s1_word_r[31:25];

  assign limit      = (budget_r < TRACE_CAP) ? budget_r : TRACE_CAP;
  assign eff_head   = s1_first_r ? s1_addr_r : head_r;
  assign eff_cnt    = s1_first_r ? '0 : cnt_r;
  assign eff_used   = s1_first_r ? '0 : used_r;
  assign eff_elig   = s1_first_r ? 1'b1 : elig_r;
  assign eff_active = s1_first_r || active_r;
  assign cnt_inc    = eff_cnt + CNT_W'(1);

  assign op_known  = op inside {OPC_LOAD, OPC_STORE, OPC_OP_IMM, OPC_OP_IMM_32, OPC_OP,
                                OPC_OP_32, OPC_AUIPC, OPC_LUI, OPC_BRANCH};
  assign is_branch = (op == OPC_BRANCH);
  assign backedge  = is_branch && ((s1_addr_r + branch_offset(s1_word_r)) == eff_head);
  assign stop_early = (eff_cnt >= limit) || !s1_ok_r || !op_known;
  assign elig_mid   = eff_elig && !(is_branch && !backedge);

  // Collect registers touched by this instruction
  always_comb begin
    collect_ok   = 1'b1;
    collect_bits = '0;
    case (op)
      OPC_OP_IMM, OPC_OP_IMM_32: begin
        collect_bits = reg_bit(rd) | reg_bit(rs1);
      end
      OPC_OP, OPC_OP_32: begin
        collect_ok   = (funct7 != FUNCT7_MULDIV);
        collect_bits = reg_bit(rd) | reg_bit(rs1) | reg_bit(rs2);
      end
      OPC_LUI, OPC_AUIPC: begin
        collect_bits = reg_bit(rd);
      end
      OPC_BRANCH: begin
        collect_bits = reg_bit(rs1) | reg_bit(rs2);
      end
      default: begin
        collect_ok = 1'b0;
      end
    endcase
  end

  assign elig_upd = elig_mid && collect_ok;
  assign used_upd = elig_upd ? (eff_used | collect_bits) : eff_used;
  assign used_pop = pop_mask(used_upd);

  // Next state and result
  always_comb begin
    head_nxt   = eff_head;
    cnt_nxt    = eff_cnt;
    used_nxt   = eff_used;
    elig_nxt   = eff_elig;
    active_nxt = eff_active;
    res_nxt    = '0;
    if (eff_active) begin
      if (stop_early) begin
        active_nxt       = 1'b0;
        res_nxt.done_res = 1'b1;
      end else begin
        used_nxt = used_upd;
        elig_nxt = elig_upd;
        if (backedge) begin
          active_nxt          = 1'b0;
          res_nxt.done_res    = 1'b1;
          res_nxt.found_loop  = 1'b1;
          res_nxt.loop_length = cnt_inc;
          if (elig_upd && (used_pop != '0) && (used_pop <= POP_W'(HOST_REG_LIMIT))) begin
            res_nxt.preload_mask  = used_upd;
            res_nxt.preload_count = used_pop;
          end
        end else begin
          cnt_nxt = cnt_inc;
          if (cnt_inc >= limit) begin
            active_nxt       = 1'b0;
            res_nxt.done_res = 1'b1;
          end
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      budget_r    <= BUDGET_RESET;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      cnt_r       <= '0;
      used_r      <= '0;
      elig_r      <= 1'b1;
      active_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        budget_r <= cfg_wr_data;
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (!out_hold) begin
        out_valid_r <= s1_valid_r;
      end
      if (advance) begin
        head_r   <= head_nxt;
        cnt_r    <= cnt_nxt;
        used_r   <= used_nxt;
        elig_r   <= elig_nxt;
        active_r <= active_nxt;
      end
    end
  end

  // Payload registers: capture a request, hold the result while stalled
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_first_r <= in_first;
      s1_addr_r  <= in_fetch_addr;
      s1_word_r  <= in_instr_word;
      s1_ok_r    <= in_fetch_ok;
    end
    if (!out_hold) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_done_res      = res_r.done_res;
  assign out_found_loop    = res_r.found_loop;
  assign out_loop_length   = res_r.loop_length;
  assign out_preload_mask  = res_r.preload_mask;
  assign out_preload_count = res_r.preload_count;

endmodule

`default_nettype wire

[rtl/lbp_checker.sv]
`default_nettype none

module lbp_checker
  import lbp_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_done_res,
  input wire logic              out_found_loop,
  input wire logic [CNT_W-1:0]  out_loop_length,
  input wire logic [MASK_W-1:0] out_preload_mask,
  input wire logic [POP_W-1:0]  out_preload_count
);

  // A result that did not close a scan carries nothing
  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |->
      (!out_found_loop && out_loop_length == '0 && out_preload_mask == '0 &&
       out_preload_count == '0))
    else $error("open-scan result carries loop fields");

  // A found loop has at least the backedge in it; no loop, no length
  a_length_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (out_found_loop == (out_loop_length != '0)))
    else $error("loop_length disagrees with found_loop");

  // A preload set exists only for a found loop and stays within the host register limit
  a_preload_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_preload_count != '0) |->
      (out_found_loop && out_preload_mask != '0 &&
       out_preload_count <= POP_W'(HOST_REG_LIMIT)))
    else $error("preload set out of range");

  // Count matches the mask
  a_preload_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (POP_W'($countones(out_preload_mask)) == out_preload_count))
    else $error("preload_count is not the mask population");

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_done_res) && $stable(out_found_loop) &&
       $stable(out_loop_length) && $stable(out_preload_mask) &&
       $stable(out_preload_count)))
    else $error("stalled result changed");

endmodule

bind loop_backedge_prescan lbp_checker u_lbp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_done_res      (out_done_res),
  .out_found_loop    (out_found_loop),
  .out_loop_length   (out_loop_length),
  .out_preload_mask  (out_preload_mask),
  .out_preload_count (out_preload_count)
);

`default_nettype wire

[bench/lbp_scan_checker.sv]
`default_nettype none

module lbp_scan_checker
  import lbp_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [CNT_W-1:0]  cfg_wr_data,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire logic              in_first,
  input  wire logic [ADDR_W-1:0] in_fetch_addr,
  input  wire logic [WORD_W-1:0] in_instr_word,
  input  wire logic              in_fetch_ok,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire logic              out_done_res,
  input  wire logic              out_found_loop,
  input  wire logic [CNT_W-1:0]  out_loop_length,
  input  wire logic [MASK_W-1:0] out_preload_mask,
  input  wire logic [POP_W-1:0]  out_preload_count,
  output int                     mismatches,
  output int                     pending
);

  // Scan results predicted per accepted request, oldest first
  lbp_res_t scan_results_q[$];

  // Own copy of the budget register and the scan state
  logic [CNT_W-1:0]  budget;
  logic [ADDR_W-1:0] head_pc;
  int                step_count;
  logic [MASK_W-1:0] live_regs;
  logic              eligible;
  logic              scanning;

  // Advance the scan by one fetched instruction and return its result
  function automatic lbp_res_t prescan_step(input logic              first,
                                            input logic [ADDR_W-1:0] pc,
                                            input logic [WORD_W-1:0] w,
                                            input logic              ok);
    lbp_res_t          r;
    logic [6:0]        opc;
    logic [12:0]       boff;
    logic [MASK_W-1:0] touched;
    logic              known;
    logic              kills;
    logic              backedge;
    int                lim;
    int                n;
    r       = '0;
    opc     = w[6:0];
    boff    = {w[31], w[7], w[30:25], w[11:8], 1'b0};
    touched = '0;
    known   = 1'b1;
    kills   = 1'b0;
    lim     = (int'(budget) < TRACE_LIMIT) ? int'(budget) : TRACE_LIMIT;

    // Open a new scan, dropping any running one
    if (first) begin
      head_pc    = pc;
      step_count = 0;
      live_regs  = '0;
      eligible   = 1'b1;
      scanning   = 1'b1;
    end
    if (!scanning) begin
      return r;
    end

    // Decode registers touched and what breaks eligibility
    case (opc)
      OPC_OP_IMM, OPC_OP_IMM_32: begin
        touched = (MASK_W'(1) << w[11:7]) | (MASK_W'(1) << w[19:15]);
      end
      OPC_OP, OPC_OP_32: begin
        touched = (MASK_W'(1) << w[11:7]) | (MASK_W'(1) << w[19:15]) |
                  (MASK_W'(1) << w[24:20]);
        kills   = (w[31:25] == FUNCT7_MULDIV);
      end
      OPC_LUI, OPC_AUIPC: begin
        touched = MASK_W'(1) << w[11:7];
      end
      OPC_BRANCH: begin
        touched = (MASK_W'(1) << w[19:15]) | (MASK_W'(1) << w[24:20]);
      end
      OPC_LOAD, OPC_STORE: begin
        kills = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
    touched[0] = 1'b0;

    // Stop without looking on spent budget, failed fetch or foreign opcode
    if (step_count >= lim || !ok || !known) begin
      scanning   = 1'b0;
      r.done_res = 1'b1;
      return r;
    end

    backedge = (opc == OPC_BRANCH) && (pc + {{(ADDR_W-13){boff[12]}}, boff} == head_pc);
    if (opc == OPC_BRANCH && !backedge) begin
      kills = 1'b1;
    end
    if (eligible) begin
      if (kills) begin
        eligible = 1'b0;
      end else begin
        live_regs = live_regs | touched;
      end
    end

    // Close on the branch back to the head
    if (backedge) begin
      scanning      = 1'b0;
      r.done_res    = 1'b1;
      r.found_loop  = 1'b1;
      r.loop_length = CNT_W'(step_count + 1);
      if (eligible) begin
        n = 0;
        for (int i = 0; i < MASK_W; i++) begin
          n += int'(live_regs[i]);
        end
        if (n >= 1 && n <= HOST_REG_LIMIT) begin
          r.preload_mask  = live_regs;
          r.preload_count = POP_W'(n);
        end
      end
      return r;
    end

    step_count++;
    if (step_count >= lim) begin
      scanning   = 1'b0;
      r.done_res = 1'b1;
    end
    return r;
  endfunction

  // Count a bad result, print only the first ten
  task automatic flag_result(input string what, input lbp_res_t want, input lbp_res_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: want done=%0d found=%0d len=%0d mask=%h cnt=%0d", $time, what,
               want.done_res, want.found_loop, want.loop_length, want.preload_mask,
               want.preload_count);
      $display("%0t %s: got  done=%0d found=%0d len=%0d mask=%h cnt=%0d", $time, what,
               got.done_res, got.found_loop, got.loop_length, got.preload_mask,
               got.preload_count);
    end
  endtask

  // Track config, predict accepted requests, compare accepted results
  always @(posedge clk) begin
    lbp_res_t got;
    lbp_res_t want;
    if (!rst_n) begin
      budget     = BUDGET_RESET;
      head_pc    = '0;
      step_count = 0;
      live_regs  = '0;
      eligible   = 1'b1;
      scanning   = 1'b0;
      mismatches = 0;
      scan_results_q.delete();
    end else begin
      if (cfg_wr_en) begin
        budget = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        scan_results_q.push_back(prescan_step(in_first, in_fetch_addr, in_instr_word,
                                              in_fetch_ok));
      end
      if (out_valid && !out_stall) begin
        got = {out_done_res, out_found_loop, out_loop_length, out_preload_mask,
               out_preload_count};
        if (scan_results_q.size() == 0) begin
          flag_result("result with no request waiting", '0, got);
        end else begin
          want = scan_results_q.pop_front();
          if (got.done_res !== want.done_res || got.found_loop !== want.found_loop ||
              got.loop_length !== want.loop_length ||
              got.preload_mask !== want.preload_mask ||
              got.preload_count !== want.preload_count) begin
            flag_result("result differs", want, got);
          end
        end
      end
    end
    pending = scan_results_q.size();
  end

endmodule

`default_nettype wire

[bench/tb_loop_backedge_prescan.sv]
`default_nettype none

module tb_loop_backedge_prescan;
  import lbp_pkg::*;

  localparam logic [ADDR_W-1:0] HEAD_WRAP = 64'hFFFF_FFFF_FFFF_FFF8;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic              in_first;
  logic [ADDR_W-1:0] in_fetch_addr;
  logic [WORD_W-1:0] in_instr_word;
  logic              in_fetch_ok;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_done_res;
  logic              out_found_loop;
  logic [CNT_W-1:0]  out_loop_length;
  logic [MASK_W-1:0] out_preload_mask;
  logic [POP_W-1:0]  out_preload_count;

  int mismatches;
  int pending;
  int sent;
  int cur_budget;
  int stall_left;
  int phase_end;
  logic calm;
  int phase_budget [8] = '{64, 1, 5, 64, 17, 0, 2, 64};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  loop_backedge_prescan u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first         (in_first),
    .in_fetch_addr    (in_fetch_addr),
    .in_instr_word    (in_instr_word),
    .in_fetch_ok      (in_fetch_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_done_res     (out_done_res),
    .out_found_loop   (out_found_loop),
    .out_loop_length  (out_loop_length),
    .out_preload_mask (out_preload_mask),
    .out_preload_count(out_preload_count)
  );

  lbp_scan_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_first         (in_first),
    .in_fetch_addr    (in_fetch_addr),
    .in_instr_word    (in_instr_word),
    .in_fetch_ok      (in_fetch_ok),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_done_res     (out_done_res),
    .out_found_loop   (out_found_loop),
    .out_loop_length  (out_loop_length),
    .out_preload_mask (out_preload_mask),
    .out_preload_count(out_preload_count),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  // Mostly short gaps, a few long ones, none while calm
  function automatic int idle_gap();
    int r;
    r = int'($urandom_range(99));
    if (calm || r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return int'($urandom_range(1, 3));
    end
    return int'($urandom_range(8, 40));
  endfunction

  // Instruction encoders with random filler fields
  function automatic logic [31:0] enc_i(input logic [6:0] op, input logic [4:0] rd,
                                        input logic [4:0] rs1);
    return {12'($urandom), rs1, 3'($urandom), rd, op};
  endfunction

  function automatic logic [31:0] enc_r(input logic [6:0] op, input logic [6:0] f7,
                                        input logic [4:0] rd, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {f7, rs2, rs1, 3'($urandom), rd, op};
  endfunction

  function automatic logic [31:0] enc_u(input logic [6:0] op, input logic [4:0] rd);
    return {20'($urandom), rd, op};
  endfunction

  function automatic logic [31:0] enc_b(input logic [12:0] off, input logic [4:0] rs1,
                                        input logic [4:0] rs2);
    return {off[12], off[10:5], rs2, rs1, 3'($urandom), off[4:1], off[11], OPC_BRANCH};
  endfunction

  function automatic logic [4:0] pick_reg(input int base, input int span);
    return 5'(base + int'($urandom_range(0, span)));
  endfunction

  // Random instruction that keeps the loop eligible
  function automatic logic [31:0] body_word(input int base, input int span);
    logic [6:0] f7;
    f7 = ($urandom_range(3) == 0) ? (7'($urandom) | 7'h02) : {1'b0, 1'($urandom), 5'd0};
    case ($urandom_range(5))
      0: return enc_i(OPC_OP_IMM, pick_reg(base, span), pick_reg(base, span));
      1: return enc_i(OPC_OP_IMM_32, pick_reg(base, span), pick_reg(base, span));
      2: return enc_r(OPC_OP, f7, pick_reg(base, span), pick_reg(base, span),
                      pick_reg(base, span));
      3: return enc_r(OPC_OP_32, f7, pick_reg(base, span), pick_reg(base, span),
                      pick_reg(base, span));
      4: return enc_u(OPC_LUI, pick_reg(base, span));
      default: return enc_u(OPC_AUIPC, pick_reg(base, span));
    endcase
  endfunction

  // Accepted instruction that takes away eligibility but not the scan
  function automatic logic [31:0] breaker_word(input int base, input int span);
    case ($urandom_range(3))
      0: return enc_u(OPC_LOAD, pick_reg(base, span));
      1: return enc_u(OPC_STORE, pick_reg(base, span));
      2: return enc_r(($urandom_range(1) != 0) ? OPC_OP : OPC_OP_32, FUNCT7_MULDIV,
                      pick_reg(base, span), pick_reg(base, span), pick_reg(base, span));
      default: return enc_b(13'(4 * $urandom_range(1, 1000)), pick_reg(base, span),
                            pick_reg(base, span));
    endcase
  endfunction

  // Drive one request after a random gap and hold it until accepted
  task automatic send(input logic first, input logic [ADDR_W-1:0] pc,
                      input logic [WORD_W-1:0] word, input logic ok);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_first      <= first;
    in_fetch_addr <= pc;
    in_instr_word <= word;
    in_fetch_ok   <= ok;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  // Write the budget once every predicted result has come back
  task automatic write_budget(input int value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CNT_W'(value);
    cur_budget = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One scan: mostly a clean loop closed by a backedge, sometimes broken
  task automatic run_loop();
    logic [ADDR_W-1:0] origin;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] pc;
    logic [WORD_W-1:0] w;
    int body;
    int base;
    int span;
    int r;
    logic lead;
    r = int'($urandom_range(99));
    if (r < 10) begin
      origin = 64'hFFFF_FFFF_FFFF_FFE0 + 64'(4 * $urandom_range(0, 7));
    end else if (r < 15) begin
      origin = 64'(4 * $urandom_range(0, 3));
    end else begin
      origin = {$urandom, $urandom};
    end
    start = origin;
    body  = ($urandom_range(9) == 0) ? int'($urandom_range(0, cur_budget + 2))
                                     : int'($urandom_range(0, 6));
    base  = int'($urandom_range(0, 31));
    span  = ($urandom_range(3) == 0) ? 31 : int'($urandom_range(0, 4));
    calm  = ($urandom_range(5) == 0);
    for (int i = 0; i <= body; i++) begin
      pc   = origin + 64'(4 * i);
      lead = (i == 0);
      r    = int'($urandom_range(99));
      if (i == body) begin
        // Close with a backward, a forward-placed or a random word
        if (r < 80) begin
          send(lead, pc, enc_b(13'(start - pc), pick_reg(base, span), pick_reg(base, span)),
               1'b1);
        end else if (r < 90) begin
          pc = start - 64'(4 * $urandom_range(1, 60));
          send(lead, pc, enc_b(13'(start - pc), pick_reg(base, span), pick_reg(base, span)),
               1'b1);
        end else begin
          send(lead, pc, $urandom, 1'b1);
        end
      end else if (r < 3) begin
        send(lead, pc, body_word(base, span), 1'b0);
        return;
      end else if (r < 5) begin
        w      = $urandom;
        w[1:0] = 2'($urandom_range(0, 2));
        send(lead, pc, w, 1'b1);
        return;
      end else if (r < 7) begin
        send(lead, pc, $urandom, 1'($urandom_range(1)));
      end else if (r < 12) begin
        send(lead, pc, breaker_word(base, span), 1'b1);
      end else if (r < 14 && !lead) begin
        start = pc;
        send(1'b1, pc, body_word(base, span), 1'b1);
      end else begin
        send(lead, pc, body_word(base, span), 1'b1);
      end
    end
  endtask

  // Hold the result side off at random, in short and long stretches
  always @(negedge clk) begin
    int r;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      r = int'($urandom_range(99));
      if (calm || r < 65) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        out_stall <= 1'b1;
        stall_left = int'($urandom_range(0, 2));
      end else begin
        out_stall <= 1'b1;
        stall_left = int'($urandom_range(10, 40));
      end
    end
  end

  // Bound the run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    in_valid      = 1'b0;
    in_first      = 1'b0;
    in_fetch_addr = '0;
    in_instr_word = '0;
    in_fetch_ok   = 1'b0;
    calm          = 1'b0;
    sent          = 0;
    cur_budget    = int'(BUDGET_RESET);
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_budget(64);

    // Request with no scan running
    send(1'b0, '1, '1, 1'b1);
    // One-instruction loop branching to itself through x0
    send(1'b1, '0, enc_b(13'd0, 5'd0, 5'd0), 1'b1);
    // Five registers, head wrapping past the top of the address space
    send(1'b1, HEAD_WRAP, enc_i(OPC_OP_IMM_32, 5'd1, 5'd2), 1'b1);
    send(1'b0, HEAD_WRAP + 64'd4, enc_r(OPC_OP_32, 7'h20, 5'd3, 5'd1, 5'd2), 1'b1);
    send(1'b0, HEAD_WRAP + 64'd8, enc_u(OPC_LUI, 5'd4), 1'b1);
    send(1'b0, HEAD_WRAP + 64'd12, enc_u(OPC_AUIPC, 5'd5), 1'b1);
    send(1'b0, HEAD_WRAP + 64'd16, enc_b(13'(-16), 5'd5, 5'd0), 1'b1);
    // Exactly the host register limit
    send(1'b1, 64'h8000_0000_0000_0000, enc_r(OPC_OP, 7'h00, 5'd1, 5'd2, 5'd3), 1'b1);
    send(1'b0, 64'h8000_0000_0000_0004, enc_i(OPC_OP_IMM, 5'd4, 5'd5), 1'b1);
    send(1'b0, 64'h8000_0000_0000_0008, enc_u(OPC_LUI, 5'd6), 1'b1);
    send(1'b0, 64'h8000_0000_0000_000C, enc_b(13'(-12), 5'd1, 5'd6), 1'b1);
    // Load and multiply make the loop ineligible
    send(1'b1, 64'h2000, enc_u(OPC_LOAD, 5'd1), 1'b1);
    send(1'b0, 64'h2004, enc_r(OPC_OP, FUNCT7_MULDIV, 5'd2, 5'd1, 5'd1), 1'b1);
    send(1'b0, 64'h2008, enc_b(13'(-8), 5'd2, 5'd0), 1'b1);
    // Store and a forward branch
    send(1'b1, 64'h4000, enc_u(OPC_STORE, 5'd9), 1'b1);
    send(1'b0, 64'h4004, enc_b(13'd64, 5'd1, 5'd2), 1'b1);
    send(1'b0, 64'h4008, enc_b(13'(-8), 5'd1, 5'd0), 1'b1);
    // Failed fetch on the head
    send(1'b1, 64'h5000, enc_i(OPC_OP_IMM, 5'd1, 5'd1), 1'b0);
    // Restart drops the running scan
    send(1'b1, 64'h6000, enc_i(OPC_OP_IMM, 5'd7, 5'd7), 1'b1);
    send(1'b1, 64'h7000, enc_i(OPC_OP_IMM, 5'd8, 5'd8), 1'b1);
    send(1'b0, 64'h7004, enc_b(13'(-4), 5'd8, 5'd0), 1'b1);
    // Backedge placed below the head
    send(1'b1, 64'h9000, enc_i(OPC_OP_IMM, 5'd10, 5'd11), 1'b1);
    send(1'b0, 64'h8FF8, enc_b(13'd8, 5'd10, 5'd0), 1'b1);
    // Budget reached, then a budget already spent when the request arrives
    write_budget(2);
    send(1'b1, 64'hA000, enc_i(OPC_OP_IMM, 5'd1, 5'd2), 1'b1);
    send(1'b0, 64'hA004, enc_i(OPC_OP_IMM, 5'd3, 5'd4), 1'b1);
    send(1'b1, 64'hB000, enc_i(OPC_OP_IMM, 5'd1, 5'd2), 1'b1);
    write_budget(1);
    send(1'b0, 64'hB004, enc_i(OPC_OP_IMM, 5'd3, 5'd4), 1'b1);

    // Random phases, one budget each
    for (int p = 0; p < 8; p++) begin
      calm = 1'b0;
      write_budget((phase_budget[p] == 0) ? int'($urandom_range(1, 64)) : phase_budget[p]);
      if ($urandom_range(1) != 0) begin
        send(1'b0, {$urandom, $urandom}, body_word(0, 31), 1'b1);
      end
      phase_end = sent + 84;
      while (sent < phase_end) run_loop();
      // Leave a scan open across the next budget change
      calm = 1'b0;
      send(1'b1, {$urandom, $urandom}, body_word(0, 31), 1'b1);
      repeat ($urandom_range(0, 4)) send(1'b0, {$urandom, $urandom}, body_word(0, 31), 1'b1);
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    calm = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

[loop_backedge_prescan.f]
rtl/lbp_pkg.sv
rtl/loop_backedge_prescan.sv
rtl/lbp_checker.sv
bench/lbp_scan_checker.sv
bench/tb_loop_backedge_prescan.sv
